[sv/totp_pkg.sv]
// Package for the TOTP token unit: SHA-1 constants, control struct.
// No dependencies.
package totp_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam int unsigned REG_KEY_BYTES = 20;
  localparam logic [19:0] CODE_MODULUS = 20'd1000000;
  // reciprocals: x/30 = (x * DIV30_MAGIC) >> 36 for 32-bit x,
  // x/1000000 = (x * MOD_MAGIC) >> 51 for 31-bit x
  localparam logic [31:0] DIV30_MAGIC = 32'h88888889;
  localparam logic [31:0] MOD_MAGIC   = 32'd2251799814;
  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KLEN = 3'd3;
  localparam logic [2:0] CFG_TZ   = 3'd4;

  typedef struct packed {
    logic         start;   // begin a compression on blk with chaining h_in
    logic [159:0] h_in;
  } sha_ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] i);
    logic [31:0] k;
    if (i < 7'd20) k = 32'h5A827999;
    else if (i < 7'd40) k = 32'h6ED9EBA1;
    else if (i < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction
endpackage

[sv/totp_sha1_core.sv]
// Iterative SHA-1 compression: one round per cycle, 16-word schedule window.
// Depends on totp_pkg.
module totp_sha1_core (
  input  logic              clk,
  input  logic              rst_n,
  input  totp_pkg::sha_ctl_t ctl,
  input  logic [511:0]      blk,
  output logic              done,
  output logic [159:0]      h_out
);
  import totp_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [159:0] hin_r;
  logic [6:0]  rnd_r;
  logic        busy_r, done_r;
  logic [31:0] f, t, wn;

  always_comb begin
    if (rnd_r < 7'd20) f = (b_r & c_r) | (~b_r & d_r);
    else if (rnd_r < 7'd40 || rnd_r >= 7'd60) f = b_r ^ c_r ^ d_r;
    else f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    t = {a_r[26:0], a_r[31:27]} + f + e_r + round_k(rnd_r) + w_r[0];
    wn = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn = {wn[30:0], wn[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        hin_r  <= ctl.h_in;
        {a_r, b_r, c_r, d_r, e_r} <= ctl.h_in;
        for (int i = 0; i < 16; i++) w_r[i] <= blk[511-32*i -: 32];
      end else if (busy_r) begin
        e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= t;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign h_out = {hin_r[159:128] + a_r, hin_r[127:96] + b_r, hin_r[95:64] + c_r,
                  hin_r[63:32] + d_r, hin_r[31:0] + e_r};

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("done held");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rnd_r < 7'd80)
    else $error("round overflow");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(rnd_r) == 7'd79) else $error("early done");
endmodule

[sv/totp_hmac_sha1_token_unit.sv]
// TOTP token unit: time offset, /30, HMAC-SHA1, truncation, mod 1e6.
// Depends on totp_pkg and totp_sha1_core.
// One code passes through the divide by 30 (reciprocal multiply), four SHA-1
// compressions (one round per cycle in the shared core plus load and handoff),
// truncation, the quotient by 1000000 and the remainder, the last two on the
// same shared multiplier. busy is high for the whole transaction, so a new
// start is taken only once busy has fallen; out_valid pulses once with the
// code and the receiver cannot stall it.
module totp_hmac_sha1_token_unit #(
  parameter int MAX_KEY_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  output logic [19:0] out_one_time_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import totp_pkg::*;

  localparam logic [4:0] LEN_CAP = (MAX_KEY_BYTES < REG_KEY_BYTES) ?
                                   5'(MAX_KEY_BYTES) : 5'(REG_KEY_BYTES);

  typedef enum logic [3:0] {S_IDLE, S_DIV, S_C0, S_W0, S_C1, S_W1, S_C2, S_W2,
                            S_C3, S_W3, S_TRUNC, S_MOD, S_OUT} state_t;

  logic [63:0] key0_r, key1_r;
  logic [31:0] key2_r;
  logic [4:0]  klen_r;
  logic [10:0] tz_r;

  state_t      st_r;
  logic [31:0] num_r, q_r;
  logic [159:0] h_r, inner_r;
  logic [511:0] blk_r;
  logic        go_r, val_r;
  logic [19:0] code_r;
  logic        core_done;
  logic [159:0] core_h;
  sha_ctl_t    ctl;

  logic [159:0] kbytes;
  logic [511:0] keyblk;
  logic [31:0]  mul_a, mul_k, res;
  logic [63:0]  mul_p;
  logic [3:0]   ofs;
  logic [30:0]  trunc;

  always_comb begin
    kbytes = {key0_r, key1_r, key2_r};
    for (int i = 0; i < 20; i++)
      if (5'(i) >= ((klen_r > LEN_CAP) ? LEN_CAP : klen_r)) kbytes[159-8*i -: 8] = 8'h00;
    keyblk = {kbytes, 352'd0};
    // shared multiplier: reciprocal for /30, reciprocal for /1e6, then q*1e6
    mul_a = (st_r == S_OUT) ? q_r : num_r;
    if (st_r == S_DIV) mul_k = DIV30_MAGIC;
    else if (st_r == S_MOD) mul_k = MOD_MAGIC;
    else mul_k = {12'd0, CODE_MODULUS};
    mul_p = {32'd0, mul_a} * {32'd0, mul_k};
    res = num_r - mul_p[31:0];
    ofs = h_r[3:0];
    trunc = h_r[158 - 8*ofs -: 31];
    ctl.start = go_r;
    ctl.h_in = (st_r == S_C1 || st_r == S_C3) ? h_r : {H0, H1, H2, H3, H4};
  end

  totp_sha1_core u_core (.clk, .rst_n, .ctl, .blk(blk_r), .done(core_done), .h_out(core_h));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; klen_r <= 5'd20; tz_r <= '0;
      st_r <= S_IDLE; go_r <= 1'b0; val_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      val_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY0: key0_r <= cfg_data;
          CFG_KEY1: key1_r <= cfg_data;
          CFG_KEY2: key2_r <= cfg_data[31:0];
          CFG_KLEN: klen_r <= cfg_data[4:0];
          CFG_TZ:   tz_r   <= cfg_data[10:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: if (start) begin
          num_r <= in_unix_seconds + 32'({{21{tz_r[10]}}, tz_r} * 32'sd60);
          st_r <= S_DIV;
        end
        S_DIV: begin
          q_r <= {4'd0, mul_p[63:36]};
          st_r <= S_C0; go_r <= 1'b1;
          blk_r <= keyblk ^ {64{8'h36}};
        end
        S_C0: st_r <= S_W0;
        S_W0: if (core_done) begin
          h_r <= core_h; st_r <= S_C1; go_r <= 1'b1;
          blk_r <= {32'd0, q_r, 8'h80, 408'd0, 32'd576};
        end
        S_C1: st_r <= S_W1;
        S_W1: if (core_done) begin
          inner_r <= core_h; st_r <= S_C2; go_r <= 1'b1;
          blk_r <= keyblk ^ {64{8'h5C}};
        end
        S_C2: st_r <= S_W2;
        S_W2: if (core_done) begin
          h_r <= core_h; st_r <= S_C3; go_r <= 1'b1;
          blk_r <= {inner_r, 8'h80, 312'd0, 32'd672};
        end
        S_C3: st_r <= S_W3;
        S_W3: if (core_done) begin
          h_r <= core_h; st_r <= S_TRUNC;
        end
        S_TRUNC: begin
          num_r <= {1'b0, trunc}; st_r <= S_MOD;
        end
        S_MOD: begin
          q_r <= {19'd0, mul_p[63:51]}; st_r <= S_OUT;
        end
        S_OUT: begin
          code_r <= res[19:0]; val_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = val_r;
  assign out_one_time_code = code_r;

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    val_r |-> code_r < CODE_MODULUS) else $error("code out of range");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    val_r |-> st_r == S_IDLE) else $error("valid while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule

[tb/totp_hmac_sha1_token_unit_tb.sv]
// Testbench for totp_hmac_sha1_token_unit: drives Unix times, predicts each
// six-digit code with an in-bench HMAC-SHA1 TOTP model. Depends on totp_pkg.
`timescale 1ns / 100ps

module totp_hmac_sha1_token_unit_tb;
  import totp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_unix_seconds = '0;
  logic        out_valid;
  logic [19:0] out_one_time_code;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_KEY0;
  logic [63:0] cfg_data = '0;

  totp_hmac_sha1_token_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_unix_seconds(in_unix_seconds), .out_valid(out_valid),
    .out_one_time_code(out_one_time_code), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // model copy of the registers
  logic [63:0] key_w0, key_w1;
  logic [31:0] key_w2;
  logic [4:0]  key_len;
  logic [10:0] tz_min;

  logic [31:0] time_queue[$];
  logic [19:0] code_queue[$];
  int          errors = 0;
  int          sent = 0;
  bit          quiet_sender = 1'b0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] compress(input logic [159:0] h,
                                            input logic [511:0] blk);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = h;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
      else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
      else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
      else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  // 64-byte padded-key block then a tail of tail_len bytes (left aligned)
  function automatic logic [159:0] hash_two(input logic [511:0] first,
                                            input logic [159:0] tail, input int tail_len);
    logic [511:0] blk;
    logic [159:0] h;
    h = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    h = compress(h, first);
    blk = '0;
    for (int i = 0; i < tail_len; i++) blk[511 - 8*i -: 8] = tail[159 - 8*i -: 8];
    blk[511 - 8*tail_len -: 8] = 8'h80;
    blk[31:0] = (64 + tail_len) * 8;
    return compress(h, blk);
  endfunction

  function automatic logic [19:0] token_for(input logic [31:0] secs);
    logic [511:0] keyb, ipad, opad;
    logic [159:0] inner, mac;
    logic [31:0]  tz, t, code;
    int           len, ofs;
    keyb = '0;
    keyb[511 -: 160] = {key_w0, key_w1, key_w2};
    len = key_len;
    if (len > 20) len = 20;
    for (int i = len; i < 64; i++) keyb[511 - 8*i -: 8] = 8'h00;
    for (int i = 0; i < 64; i++) begin
      ipad[511 - 8*i -: 8] = keyb[511 - 8*i -: 8] ^ 8'h36;
      opad[511 - 8*i -: 8] = keyb[511 - 8*i -: 8] ^ 8'h5C;
    end
    tz = {{21{tz_min[10]}}, tz_min};
    t = (secs + tz * 32'd60) / 32'd30;
    inner = hash_two(ipad, {32'h0, t, 96'h0}, 8);
    mac = hash_two(opad, inner, 20);
    ofs = mac[3:0];
    code = {1'b0, mac[158 - 8*ofs -: 31]};
    return 20'(code % 32'd1000000);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      code_queue.push_back(token_for(in_unix_seconds));
      sent++;
      if (time_queue.size() > 0 && (quiet_sender || $urandom_range(99) >= 7)) begin
        in_unix_seconds <= time_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && time_queue.size() > 0 &&
                 (quiet_sender || $urandom_range(99) >= 7)) begin
      start <= 1'b1;
      in_unix_seconds <= time_queue.pop_front();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (code_queue.size() == 0) begin
        $display("%0t: unexpected code, expected none, actual %0d", $time, out_one_time_code);
        errors++;
      end else begin
        logic [19:0] exp_code;
        exp_code = code_queue.pop_front();
        if (out_one_time_code !== exp_code) begin
          $display("%0t: code mismatch, expected %0d, actual %0d",
                   $time, exp_code, out_one_time_code);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      CFG_KEY0: key_w0 = val;
      CFG_KEY1: key_w1 = val;
      CFG_KEY2: key_w2 = val[31:0];
      CFG_KLEN: key_len = val[4:0];
      CFG_TZ:   tz_min = val[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (time_queue.size() > 0 || start || code_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_times(input int n);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = $urandom_range(100);
        1: v = 32'hFFFF_FFFF - $urandom_range(100000);
        default: v = $urandom;
      endcase
      time_queue.push_back(v);
    end
  endtask

  initial begin
    logic [63:0] lens[6];
    logic [63:0] tzs[6];
    key_w0 = '0; key_w1 = '0; key_w2 = '0; key_len = 5'd20; tz_min = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // RFC-style ASCII key "12345678901234567890"
    write_reg(CFG_KEY0, 64'h3132333435363738);
    write_reg(CFG_KEY1, 64'h3930313233343536);
    write_reg(CFG_KEY2, 64'h37383930);
    time_queue.push_back(32'd59);
    time_queue.push_back(32'd1111111109);
    time_queue.push_back(32'd1234567890);
    time_queue.push_back(32'd2000000000);
    time_queue.push_back(32'd0);
    time_queue.push_back(32'hFFFFFFFF);
    time_queue.push_back(32'd29);
    time_queue.push_back(32'd30);
    drain();
    // empty key, oversize length, negative/positive timezone wrap
    write_reg(CFG_KLEN, 64'd0);
    time_queue.push_back(32'd59);
    drain();
    write_reg(CFG_KLEN, 64'd31);
    write_reg(CFG_TZ, 64'h400);
    time_queue.push_back(32'd0);
    time_queue.push_back(32'd100);
    drain();
    write_reg(CFG_TZ, 64'h3FF);
    time_queue.push_back(32'hFFFFFFFF);
    drain();
    lens = '{64'd1, 64'd20, 64'd7, 64'd0, 64'd25, 64'd13};
    tzs = '{-64'sd840, 64'd840, 64'd0, 64'd330, 64'h7FF, 64'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_KEY0, {$urandom, $urandom});
      write_reg(CFG_KEY1, p == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      write_reg(CFG_KEY2, p == 0 ? 64'hFFFF_FFFF : {32'h0, $urandom});
      write_reg(CFG_KLEN, lens[p]);
      write_reg(CFG_TZ, tzs[p]);
      quiet_sender = (p == 2);
      random_times(200);
      drain();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[files.f]
sv/totp_pkg.sv
sv/totp_sha1_core.sv
sv/totp_hmac_sha1_token_unit.sv
tb/totp_hmac_sha1_token_unit_tb.sv
